>>> rtl/mmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_pkg
// Shared types and codes for the multiset mex tracker: field widths, status
// codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mmt_pkg;

  localparam int unsigned VAL_W  = 16;
  localparam int unsigned LIM_W  = 10;
  localparam int unsigned MEX_W  = 11;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd1023;

  localparam logic [STAT_W-1:0] STS_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STS_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] STS_ABSENT  = 2'd2;
  localparam logic [STAT_W-1:0] STS_SAT     = 2'd3;

  localparam logic ACT_INSERT = 1'b0;

  typedef struct packed {
    logic clear;
    logic accept;
    logic rd_item;
    logic modify;
    logic clamp;
    logic rd_walk;
    logic step;
    logic load_out;
  } mmt_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic ignored;
    logic walk_end;
    logic walk_nonzero;
    logic out_free;
  } mmt_sts_t;

endpackage
`default_nettype wire

>>> rtl/mmt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module mmt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/mmt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_ctrl
// Sequencer: clearing pass, read-modify-write of one count, mex clamp and
// upward walk, result hand-off.
// ----------------------------------------------------------------------------
module mmt_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  mmt_pkg::mmt_sts_t sts,
  output mmt_pkg::mmt_cmd_t cmd
);
  import mmt_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_READ    = 8'b0000_0100,
    S_MODIFY  = 8'b0000_1000,
    S_CLAMP   = 8'b0001_0000,
    S_WALK_RD = 8'b0010_0000,
    S_WALK_CK = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_READ;
        end
      end
      S_READ: begin
        if (sts.ignored) begin
          state_nxt = S_CLAMP;
        end else begin
          cmd.rd_item = 1'b1;
          state_nxt   = S_MODIFY;
        end
      end
      S_MODIFY: begin
        cmd.modify = 1'b1;
        state_nxt  = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_WALK_RD;
      end
      S_WALK_RD: begin
        if (sts.walk_end) begin
          state_nxt = S_DONE;
        end else begin
          cmd.rd_walk = 1'b1;
          state_nxt   = S_WALK_CK;
        end
      end
      S_WALK_CK: begin
        if (sts.walk_nonzero) begin
          cmd.step  = 1'b1;
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mmt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_datapath
// Count store, mex register and result register, driven by the sequencer's
// commands, and the limit register, written through the cfg port.
// ----------------------------------------------------------------------------
module mmt_datapath #(
  parameter int unsigned VALUE_SLOTS = 1024,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  mmt_pkg::mmt_cmd_t                  cmd,
  output mmt_pkg::mmt_sts_t                  sts,
  input  wire [mmt_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire                                in_tuser,
  input  wire                                cfg_we,
  input  wire [mmt_pkg::LIM_W-1:0]           cfg_wdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [mmt_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [mmt_pkg::STAT_W-1:0]         out_tuser
);
  import mmt_pkg::*;

  localparam int unsigned AW = $clog2(VALUE_SLOTS);

  logic [LIM_W-1:0]      limit_r;
  logic [MEX_W-1:0]      mex_r;
  logic                  action_r;
  logic [VAL_W-1:0]      value_r;
  logic [STAT_W-1:0]     status_r;
  logic [AW-1:0]         clr_cnt_r;
  logic                  out_tvalid_r;
  logic [MEX_W-1:0]      out_mex_r;
  logic [STAT_W-1:0]     out_status_r;

  logic [MEX_W-1:0]      lim_p1;
  logic [MEX_W-1:0]      bound;
  logic                  out_of_range;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [AW-1:0]         item_addr;
  logic [AW-1:0]         mex_addr;

  assign lim_p1 = {1'b0, limit_r} + MEX_W'(1);
  assign bound  = (32'(lim_p1) > VALUE_SLOTS) ? MEX_W'(VALUE_SLOTS) : lim_p1;

  assign out_of_range = (in_tdata[VAL_W-1:0] > {{(VAL_W-LIM_W){1'b0}}, limit_r}) ||
                        (32'(in_tdata[VAL_W-1:0]) >= VALUE_SLOTS);

  assign item_addr = AW'(value_r);
  assign mex_addr  = AW'(mex_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = item_addr;
    ram_wdata = ram_rdata;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.modify) begin
      if (action_r == ACT_INSERT) begin
        ram_we    = (ram_rdata != '1);
        ram_wdata = ram_rdata + COUNT_BITS'(1);
      end else begin
        ram_we    = (ram_rdata != '0);
        ram_wdata = ram_rdata - COUNT_BITS'(1);
      end
    end
  end

  assign ram_re    = cmd.rd_item | cmd.rd_walk;
  assign ram_raddr = cmd.rd_walk ? mex_addr : item_addr;

  mmt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (VALUE_SLOTS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= LIMIT_RESET;
      mex_r        <= '0;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.modify && action_r != ACT_INSERT && ram_rdata == COUNT_BITS'(1) &&
          {{(VAL_W-MEX_W){1'b0}}, mex_r} > value_r) begin
        mex_r <= MEX_W'(value_r);
      end
      if (cmd.clamp && mex_r > bound) mex_r <= bound;
      if (cmd.step) mex_r <= mex_r + MEX_W'(1);
      if (cmd.load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_tuser;
      value_r  <= in_tdata[VAL_W-1:0];
      status_r <= out_of_range ? STS_IGNORED : STS_DONE;
    end
    if (cmd.modify) begin
      if (action_r == ACT_INSERT) begin
        if (ram_rdata == '1) status_r <= STS_SAT;
      end else begin
        if (ram_rdata == '0) status_r <= STS_ABSENT;
      end
    end
    if (cmd.load_out) begin
      out_mex_r    <= mex_r;
      out_status_r <= status_r;
    end
  end

  assign sts.clear_last   = (clr_cnt_r == AW'(VALUE_SLOTS - 1));
  assign sts.ignored      = (status_r == STS_IGNORED);
  assign sts.walk_end     = (mex_r >= bound);
  assign sts.walk_nonzero = (ram_rdata != '0);
  assign sts.out_free     = !out_tvalid_r || out_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-MEX_W){1'b0}}, out_mex_r};
  assign out_tuser  = out_status_r;

endmodule
`default_nettype wire

>>> rtl/multiset_mex_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiset_mex_tracker
// Per-value occurrence counts with a running mex (least value whose count is
// zero, capped at min(limit+1, VALUE_SLOTS)), one result word per input word.
// ----------------------------------------------------------------------------
// After reset the block sweeps the count store to zero, one entry a cycle,
// with in_tready low; cfg writes are taken throughout. An item then runs from
// acceptance through the count read, the count update, the mex clamp and the
// upward walk to the result register; an ignored value skips the read and
// update, and the walk ends without a read once the mex is at the bound. The
// count RAM has one read port and a registered read, so every upward step is
// a read and a check. Removals and ignored values never advance the mex except
// after a limit change. A new word is accepted once the result is loaded, at
// the earliest in the cycle after the load, even while that result still
// waits on out_tready; loading waits while the previous result is still held.
module multiset_mex_tracker #(
  parameter int unsigned VALUE_SLOTS = 1024,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire [mmt_pkg::IN_TDATA_W-1:0]    in_tdata,   // value[15:0]
  input  wire                              in_tuser,   // action[0]
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [mmt_pkg::OUT_TDATA_W-1:0]  out_tdata,  // mex[10:0], zeros[15:11]
  output logic [mmt_pkg::STAT_W-1:0]       out_tuser,  // status[1:0]
  input  wire                              cfg_we,
  input  wire [mmt_pkg::LIM_W-1:0]         cfg_wdata
);
  import mmt_pkg::*;

  mmt_cmd_t cmd;
  mmt_sts_t sts;

  mmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mmt_datapath #(
    .VALUE_SLOTS (VALUE_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

>>> rtl/mmt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmt_checker
// Port-level checks for the multiset mex tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mmt_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [mmt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire [mmt_pkg::STAT_W-1:0]        out_tuser
);

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("input ready or output valid right after reset");

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while one is in flight");

  a_mex_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[10:0] <= 11'd1024 && out_tdata[15:11] == 5'd0)
    else $error("mex beyond largest bound");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result word changed");

endmodule

bind multiset_mex_tracker mmt_checker u_mmt_checker (.*);
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multiset_mex_tracker. A driver feeds insert and
// remove words from a pending queue, a monitor predicts mex and status for
// every accepted word and compares the result stream against that forecast.
// Covers absent removals, ignored values, a full fill to the top mex, limit
// changes and randomized traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import mmt_pkg::*;

  localparam logic ACT_REMOVE = 1'b1;
  localparam int unsigned SLOTS = 1024;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic             action;
    logic [VAL_W-1:0] value;
  } op_word_t;

  typedef struct packed {
    logic [MEX_W-1:0]  mex;
    logic [STAT_W-1:0] status;
  } mex_word_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;
  logic                   cfg_we = 1'b0;
  logic [LIM_W-1:0]       cfg_wdata = '0;

  // predictor state
  logic [15:0]      tally [SLOTS];
  logic [MEX_W-1:0] held_mex;
  logic [LIM_W-1:0] value_limit;

  op_word_t  pending_ops[$];
  mex_word_t expected_answers[$];

  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned hold_gap = 0;
  int unsigned stall_cycles = 0;
  int unsigned ops_queued = 0;
  int unsigned ops_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned limit_writes = 0;
  int unsigned fails = 0;
  int unsigned status_seen [4];
  logic [MEX_W-1:0] peak_mex = '0;

  multiset_mex_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // value[15:0]
    .in_tuser   (in_tuser),   // action[0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // mex[10:0], zeros[15:11]
    .out_tuser  (out_tuser),  // status[1:0]
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic mex_word_t apply_update(logic act, logic [VAL_W-1:0] val);
    mex_word_t        r;
    logic [MEX_W-1:0] bound;
    bound = {1'b0, value_limit} + 1'b1;
    r.status = STS_DONE;
    if (val > {{(VAL_W-LIM_W){1'b0}}, value_limit}) begin
      r.status = STS_IGNORED;
    end else if (act == ACT_INSERT) begin
      if (tally[val[LIM_W-1:0]] == 16'hFFFF) r.status = STS_SAT;
      else tally[val[LIM_W-1:0]] = tally[val[LIM_W-1:0]] + 1'b1;
    end else begin
      if (tally[val[LIM_W-1:0]] == '0) begin
        r.status = STS_ABSENT;
      end else begin
        tally[val[LIM_W-1:0]] = tally[val[LIM_W-1:0]] - 1'b1;
        if (tally[val[LIM_W-1:0]] == '0 && held_mex > val[MEX_W-1:0])
          held_mex = val[MEX_W-1:0];
      end
    end
    if (held_mex > bound) held_mex = bound;
    while (held_mex < bound && tally[held_mex[LIM_W-1:0]] != '0)
      held_mex = held_mex + 1'b1;
    r.mex = held_mex;
    return r;
  endfunction

  // driver: advance on acceptance, hold otherwise
  always @(negedge clk) begin
    op_word_t next_op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        next_op = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= next_op.value;
        in_tuser <= next_op.action;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_gap != 0) begin
      hold_gap = hold_gap - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      hold_gap = $urandom_range(0, 14);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on input acceptance, check on result acceptance
  always @(posedge clk) begin
    mex_word_t want;
    in_fire = rst_n && in_tvalid && in_tready;
    out_fire = rst_n && out_tvalid && out_tready;
    if (in_fire) begin
      expected_answers.push_back(apply_update(in_tuser, in_tdata));
      ops_accepted++;
    end
    if (out_fire) begin
      results_checked++;
      if (expected_answers.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS)
          $display("%0t: result with nothing expected, actual mex %0d status %0d",
                   $time, out_tdata, out_tuser);
      end else begin
        want = expected_answers.pop_front();
        status_seen[want.status]++;
        if (want.mex > peak_mex) peak_mex = want.mex;
        if (out_tdata !== {{(OUT_TDATA_W-MEX_W){1'b0}}, want.mex}) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: mex expected %0d actual %0d", $time, want.mex, out_tdata);
        end
        if (out_tuser !== want.status) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_tuser);
        end
      end
    end
    if (in_fire || out_fire) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_op(input logic act, input logic [VAL_W-1:0] val);
    op_word_t w;
    w.action = act;
    w.value = val;
    pending_ops.push_back(w);
    ops_queued++;
  endtask

  task automatic drain_all();
    while (ops_accepted != ops_queued || expected_answers.size() != 0) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] lim);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lim;
    value_limit = lim;
    limit_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(input logic [LIM_W-1:0] lim, input int unsigned window,
                                  input int unsigned count);
    int unsigned pick;
    logic [VAL_W-1:0] val;
    write_limit(lim);
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) val = VAL_W'($urandom_range(0, window));
      else if (pick < 17) val = VAL_W'($urandom_range(0, SLOTS - 1));
      else val = VAL_W'($urandom);
      queue_op($urandom_range(0, 1) ? ACT_REMOVE : ACT_INSERT, val);
    end
    drain_all();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) tally[i] = '0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    held_mex = '0;
    value_limit = LIMIT_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: absent removal, ignored values, walk and drop of the mex
    write_limit(LIMIT_RESET);
    queue_op(ACT_REMOVE, 16'd0);
    queue_op(ACT_INSERT, 16'd0);
    queue_op(ACT_INSERT, 16'd0);
    queue_op(ACT_REMOVE, 16'd0);
    queue_op(ACT_REMOVE, 16'd0);
    queue_op(ACT_INSERT, 16'd1023);
    queue_op(ACT_INSERT, 16'd1024);
    queue_op(ACT_REMOVE, 16'hFFFF);
    queue_op(ACT_INSERT, 16'h5555);
    queue_op(ACT_REMOVE, 16'hAAAA);
    queue_op(ACT_INSERT, 16'd2);
    queue_op(ACT_INSERT, 16'd1);
    queue_op(ACT_INSERT, 16'd0);
    queue_op(ACT_REMOVE, 16'd1);
    queue_op(ACT_INSERT, 16'd1);
    queue_op(ACT_REMOVE, 16'd1023);
    drain_all();

    // smallest limit: mex capped at its bound of one, dropping to zero and back
    write_limit('0);
    queue_op(ACT_INSERT, 16'd0);
    queue_op(ACT_INSERT, 16'd1);
    queue_op(ACT_REMOVE, 16'd0);
    queue_op(ACT_REMOVE, 16'd0);
    queue_op(ACT_INSERT, 16'd0);
    drain_all();

    // raise limit again: mex walks past held counts
    write_limit(LIMIT_RESET);
    queue_op(ACT_REMOVE, 16'd5);
    drain_all();

    // fill every slot so the mex reaches its top
    for (int i = 0; i < SLOTS; i++) queue_op(ACT_INSERT, VAL_W'(i));
    drain_all();

    // clamp to a low limit, then release for a long walk
    write_limit(10'd9);
    queue_op(ACT_INSERT, 16'd5);
    drain_all();
    write_limit(LIMIT_RESET);
    queue_op(ACT_REMOVE, 16'hFFFF);
    drain_all();

    run_random_phase(10'd1023, 40, 50);
    run_random_phase(10'd0, 3, 50);
    run_random_phase(10'd1, 4, 50);
    run_random_phase(10'd37, 45, 50);
    run_random_phase(LIM_W'($urandom_range(0, SLOTS - 1)), 64, 50);
    run_random_phase(10'd511, 24, 50);
    run_random_phase(10'd1023, SLOTS - 1, 50);
    idle_on = 1'b0;
    run_random_phase(10'd1023, 30, 50);

    drain_all();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Checked %0d results for %0d accepted words over %0d limit settings.",
             results_checked, ops_accepted, limit_writes);
    $display("Status mix done/ignored/absent/saturated: %0d/%0d/%0d/%0d, peak mex %0d.",
             status_seen[STS_DONE], status_seen[STS_IGNORED], status_seen[STS_ABSENT],
             status_seen[STS_SAT], peak_mex);
    if (fails == 0 && expected_answers.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> multiset_mex_tracker.f
rtl/mmt_pkg.sv
rtl/mmt_ram.sv
rtl/mmt_ctrl.sv
rtl/mmt_datapath.sv
rtl/multiset_mex_tracker.sv
rtl/mmt_checker.sv
bench/testbench.sv
